// ----- sv/ggc_pkg.sv -----
// Shared constants and types for the greedy graph colouring core.
// No dependencies; imported by the interfaces and all ggc modules.
`default_nettype none

package ggc_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int VERTEX_W     = 12;
  localparam int MAX_COLORS   = 64;
  localparam int COLOR_W      = 6;
  localparam int COUNT_W      = 7;
  localparam int STORE_W      = 7;

  localparam logic [STORE_W-1:0] UNCOLORED = 7'h7F;

  localparam logic OP_ADJ   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic               step;
    logic               clear;
    logic               mark;
    logic [COLOR_W-1:0] mark_color;
    logic               last;
  } ggc_sel_ctl_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               overflow;
    logic [COUNT_W-1:0] count;
  } ggc_sel_res_t;

endpackage

`default_nettype wire

// ----- sv/ggc_if.sv -----
// Valid/ready channel interfaces for adjacency beats in and colour results out.
// Depends on ggc_pkg.
`default_nettype none

interface ggc_in_if import ggc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [VERTEX_W-1:0] vertex;
  logic [VERTEX_W-1:0] neighbour;
  logic                neighbour_valid;
  logic                last_entry;

  modport source (output valid, opcode, vertex, neighbour, neighbour_valid, last_entry,
                  input ready);
  modport sink   (input valid, opcode, vertex, neighbour, neighbour_valid, last_entry,
                  output ready);
endinterface

interface ggc_out_if import ggc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] colored_vertex;
  logic [COLOR_W-1:0]  assigned_color;
  logic [COUNT_W-1:0]  colors_in_use;
  logic                overflow;

  modport source (output valid, colored_vertex, assigned_color, colors_in_use, overflow,
                  input ready);
  modport sink   (input valid, colored_vertex, assigned_color, colors_in_use, overflow,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/greedy_graph_coloring_core.sv -----
// Greedy graph colouring core: top level with handshake, forwarding and clear walk.
// Depends on ggc_pkg, ggc_if, ggc_color_ram and ggc_color_select.
// Throughput: one adjacency beat per cycle, set by the single colour store read port,
// except during a clear walk or while stage 1 holds a last beat for a busy output.
// A result is registered out from stage 1 once the output is free. A clear beat, and
// reset, walk all MAX_VERTICES (4096) entries; no input beat is accepted meanwhile.
`default_nettype none

module greedy_graph_coloring_core import ggc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  ggc_in_if.sink    in_ch,
  ggc_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } ggc_state_t;

  ggc_state_t         state;
  logic [ADDR_W-1:0]  clear_index;

  logic               s1_valid;
  logic [ADDR_W-1:0]  s1_vertex;
  logic               s1_nvalid;
  logic               s1_last;
  logic               s1_fwd;
  logic [COLOR_W-1:0] s1_fwd_color;

  logic               out_free;
  logic               s1_done;
  logic               accept;
  logic               acc_adj;
  logic               acc_clear;
  logic               s1_wr;
  logic [STORE_W-1:0] rd_data;
  logic [STORE_W-1:0] nb_color;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [STORE_W-1:0] wr_data;
  ggc_sel_ctl_t       sel_ctl;
  ggc_sel_res_t       sel_res;

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign s1_done     = !s1_last || out_free;
  assign in_ch.ready = (state == ST_RUN) && (!s1_valid || s1_done);
  assign accept      = in_ch.valid && in_ch.ready;
  assign acc_adj     = accept && (in_ch.opcode == OP_ADJ);
  assign acc_clear   = accept && (in_ch.opcode == OP_CLEAR);
  assign s1_wr       = s1_valid && s1_last && out_free;
  assign nb_color    = s1_fwd ? {1'b0, s1_fwd_color} : rd_data;

  always_comb begin
    sel_ctl.step       = s1_valid && s1_done;
    sel_ctl.clear      = acc_clear;
    sel_ctl.mark       = s1_valid && s1_nvalid && !nb_color[STORE_W-1];
    sel_ctl.mark_color = nb_color[COLOR_W-1:0];
    sel_ctl.last       = s1_last;
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clear_index;
      wr_data = UNCOLORED;
    end else begin
      wr_en   = s1_wr;
      wr_addr = s1_vertex;
      wr_data = {1'b0, sel_res.color};
    end
  end

  ggc_color_ram u_ram (
    .clk     (clk),
    .rd_en   (acc_adj),
    .rd_addr (in_ch.neighbour[ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ggc_color_select u_sel (
    .clk (clk),
    .rst (rst),
    .ctl (sel_ctl),
    .res (sel_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clear_index <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clear_index <= clear_index + ADDR_W'(1);
          if (clear_index == ADDR_W'(MAX_VERTICES - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (acc_clear) begin
            state       <= ST_CLEAR;
            clear_index <= '0;
          end
        end
        default: begin
          state       <= ST_CLEAR;
          clear_index <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc_adj) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_adj) begin
      s1_vertex    <= in_ch.vertex[ADDR_W-1:0];
      s1_nvalid    <= in_ch.neighbour_valid;
      s1_last      <= in_ch.last_entry;
      s1_fwd       <= s1_wr && (s1_vertex == in_ch.neighbour[ADDR_W-1:0]);
      s1_fwd_color <= sel_res.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (s1_wr) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      out_ch.colored_vertex <= VERTEX_W'(s1_vertex);
      out_ch.assigned_color <= sel_res.color;
      out_ch.colors_in_use  <= sel_res.count;
      out_ch.overflow       <= sel_res.overflow;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ggc_color_ram.sv -----
// Colour store: one write port and one registered read port.
// Depends on ggc_pkg.
`default_nettype none

module ggc_color_ram import ggc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [STORE_W-1:0] rd_data,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [STORE_W-1:0] wr_data
);

  logic [STORE_W-1:0] mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/ggc_color_select.sv -----
// Used-colour mask, lowest free colour search and colour count.
// Depends on ggc_pkg.
`default_nettype none

module ggc_color_select import ggc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire ggc_sel_ctl_t ctl,
  output ggc_sel_res_t      res
);

  logic [MAX_COLORS-1:0] used_mask;
  logic [MAX_COLORS-1:0] mask_cur;
  logic [COUNT_W-1:0]    color_count;
  logic [COUNT_W-1:0]    chosen_inc;

  always_comb begin
    mask_cur = used_mask;
    if (ctl.mark) begin
      mask_cur[ctl.mark_color] = 1'b1;
    end
    res.color    = COLOR_W'(MAX_COLORS - 1);
    res.overflow = 1'b1;
    for (int c = MAX_COLORS - 1; c >= 0; c--) begin
      if (!mask_cur[c]) begin
        res.color    = COLOR_W'(c);
        res.overflow = 1'b0;
      end
    end
    chosen_inc = {1'b0, res.color} + COUNT_W'(1);
    res.count  = (chosen_inc > color_count) ? chosen_inc : color_count;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      used_mask   <= '0;
      color_count <= '0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        used_mask   <= '0;
        color_count <= res.count;
      end else begin
        used_mask <= mask_cur;
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for greedy_graph_coloring_core: directed, colour exhaustion and random graph tests.
// Predicts each colouring from its own copy of the colour store and checks every result beat.
// Depends on ggc_pkg, ggc_if and the core RTL.

module tb_top;
  import ggc_pkg::*;

  typedef struct packed {
    logic                opcode;
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] neighbour;
    logic                neighbour_valid;
    logic                last_entry;
  } adj_beat_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [COLOR_W-1:0]  colour;
    logic [COUNT_W-1:0]  in_use;
    logic                overflow;
  } colour_res_t;

  logic clk = 1'b0;
  logic rst;

  ggc_in_if  in_ch ();
  ggc_out_if out_ch ();

  greedy_graph_coloring_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [STORE_W-1:0]    colour_of [MAX_VERTICES];
  logic [MAX_COLORS-1:0] seen_mask;
  logic [COUNT_W-1:0]    colours_handed;
  colour_res_t           expected_colours [$];
  int                    mismatches = 0;
  int                    src_burst = 0;
  int                    sink_burst = 0;

  task automatic flag_mismatch(input string what);
    if (mismatches < 100) $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void wipe_colours();
    foreach (colour_of[i]) colour_of[i] = UNCOLORED;
    seen_mask = '0;
    colours_handed = '0;
  endfunction

  function automatic void predict_colouring(input adj_beat_t b);
    colour_res_t r;
    int          c;
    if (b.opcode == OP_CLEAR) begin
      wipe_colours();
      return;
    end
    if (b.neighbour_valid && colour_of[b.neighbour] != UNCOLORED)
      seen_mask[colour_of[b.neighbour][COLOR_W-1:0]] = 1'b1;
    if (!b.last_entry) return;
    r.vertex = b.vertex;
    r.colour = COLOR_W'(MAX_COLORS - 1);
    r.overflow = 1'b1;
    for (c = 0; c < MAX_COLORS; c++) begin
      if (!seen_mask[c]) begin
        r.colour = COLOR_W'(c);
        r.overflow = 1'b0;
        break;
      end
    end
    colour_of[b.vertex] = STORE_W'(r.colour);
    if (int'(r.colour) + 1 > int'(colours_handed))
      colours_handed = COUNT_W'(int'(r.colour) + 1);
    r.in_use = colours_handed;
    seen_mask = '0;
    expected_colours.insert(expected_colours.size(), r);
  endfunction

  // Draws a random idle run, with occasional stretches of none at all.
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic adj_beat_t beat_of(input logic op, input int v, input int n,
                                        input logic nv, input logic le);
    adj_beat_t b;
    b.opcode = op;
    b.vertex = VERTEX_W'(v);
    b.neighbour = VERTEX_W'(n);
    b.neighbour_valid = nv;
    b.last_entry = le;
    return b;
  endfunction

  function automatic adj_beat_t random_beat();
    return beat_of(OP_ADJ, $urandom_range(0, MAX_VERTICES - 1),
                   $urandom_range(0, MAX_VERTICES - 1), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
  endfunction

  function automatic int pool_vertex(input int base, input int pool);
    return (base + $urandom_range(0, pool - 1)) % MAX_VERTICES;
  endfunction

  task automatic send_beat(input adj_beat_t b);
    int gap;
    gap = draw_wait(src_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= b.opcode;
    in_ch.vertex          <= b.vertex;
    in_ch.neighbour       <= b.neighbour;
    in_ch.neighbour_valid <= b.neighbour_valid;
    in_ch.last_entry      <= b.last_entry;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_colouring(b);
  endtask

  task automatic test_directed_cases();
    send_beat(beat_of(OP_ADJ, 0, 12'hFFF, 1'b0, 1'b1));
    send_beat(beat_of(OP_ADJ, 4095, 0, 1'b1, 1'b1));
    send_beat(beat_of(OP_ADJ, 12'h555, 12'hFFF, 1'b0, 1'b0));
    send_beat(beat_of(OP_ADJ, 12'h555, 12'hAAA, 1'b1, 1'b0));
    send_beat(beat_of(OP_ADJ, 12'h555, 0, 1'b1, 1'b0));
    send_beat(beat_of(OP_ADJ, 12'h555, 12'h555, 1'b1, 1'b1));
    send_beat(beat_of(OP_ADJ, 12'hAAA, 12'h555, 1'b1, 1'b0));
    send_beat(beat_of(OP_ADJ, 12'hAAA, 0, 1'b1, 1'b0));
    send_beat(beat_of(OP_ADJ, 12'hAAA, 12'hFFF, 1'b1, 1'b1));
    send_beat(beat_of(OP_ADJ, 12'hAAA, 12'hAAA, 1'b1, 1'b1));
    send_beat(beat_of(OP_ADJ, 0, 12'hAAA, 1'b1, 1'b0));
    send_beat(beat_of(OP_ADJ, 0, 12'h555, 1'b1, 1'b0));
    send_beat(beat_of(OP_ADJ, 0, 12'h555, 1'b1, 1'b0));
    send_beat(beat_of(OP_ADJ, 0, 4095, 1'b0, 1'b1));
    send_beat(beat_of(OP_CLEAR, 12'hFFF, 12'hFFF, 1'b1, 1'b1));
    send_beat(beat_of(OP_ADJ, 4095, 0, 1'b1, 1'b1));
    send_beat(beat_of(OP_ADJ, 0, 4095, 1'b1, 1'b1));
    send_beat(beat_of(OP_CLEAR, 0, 0, 1'b0, 1'b0));
    send_beat(beat_of(OP_ADJ, 12'h7FF, 12'h800, 1'b1, 1'b1));
    send_beat(beat_of(OP_ADJ, 12'h800, 12'h7FF, 1'b1, 1'b0));
    send_beat(beat_of(OP_ADJ, 12'h123, 12'h7FF, 1'b1, 1'b1));
  endtask

  // Clear, build a ladder where vertex j sees colours 0..j-1 up to one that sees them all, then recolour vertex 0.
  task automatic test_colour_exhaustion();
    int        ladder [MAX_COLORS + 1];
    int        order [MAX_COLORS];
    int        base, j, k, pick, tmp;
    adj_beat_t b;
    base = $urandom_range(0, MAX_VERTICES - 1);
    for (j = 0; j <= MAX_COLORS; j++) ladder[j] = (base + 37 * j) % MAX_VERTICES;
    b = random_beat();
    b.opcode = OP_CLEAR;
    send_beat(b);
    for (j = 0; j <= MAX_COLORS; j++) begin
      if (j == 0) begin
        send_beat(beat_of(OP_ADJ, ladder[0], $urandom_range(0, MAX_VERTICES - 1), 1'b0, 1'b1));
        continue;
      end
      for (k = 0; k < j; k++) order[k] = k;
      for (k = j - 1; k > 0; k--) begin
        pick = $urandom_range(0, k);
        tmp = order[k];
        order[k] = order[pick];
        order[pick] = tmp;
      end
      for (k = 0; k < j; k++)
        send_beat(beat_of(OP_ADJ, ladder[j], ladder[order[k]], 1'b1, k == j - 1));
    end
    send_beat(beat_of(OP_ADJ, ladder[0], ladder[MAX_COLORS], 1'b1, 1'b1));
  endtask

  task automatic test_random_graphs(input int n_items);
    int        sent, clears, base, pool, nverts, deg, k;
    adj_beat_t b;
    sent = 0;
    clears = 0;
    while (sent < n_items) begin
      if (clears < 8 && $urandom_range(0, 5) == 0) begin
        b = random_beat();
        b.opcode = OP_CLEAR;
        send_beat(b);
        clears++;
      end
      base = $urandom_range(0, MAX_VERTICES - 1);
      pool = $urandom_range(4, 40);
      nverts = $urandom_range(5, 40);
      repeat (nverts) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            b = random_beat();
            if ($urandom_range(0, 1) == 0) b.vertex = VERTEX_W'(pool_vertex(base, pool));
            if ($urandom_range(0, 1) == 0) b.neighbour = VERTEX_W'(pool_vertex(base, pool));
            send_beat(b);
            sent++;
          end
        end else begin
          deg = $urandom_range(0, 8);
          b = random_beat();
          b.vertex = VERTEX_W'(pool_vertex(base, pool));
          if (deg == 0) begin
            b.neighbour_valid = 1'b0;
            b.last_entry = 1'b1;
            send_beat(b);
            sent++;
          end
          for (k = 0; k < deg; k++) begin
            b.neighbour = VERTEX_W'(pool_vertex(base, pool));
            b.neighbour_valid = ($urandom_range(0, 9) != 0);
            b.last_entry = (k == deg - 1);
            send_beat(b);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin : result_checker
    int          stall;
    colour_res_t got, want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait(sink_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      got.vertex = out_ch.colored_vertex;
      got.colour = out_ch.assigned_color;
      got.in_use = out_ch.colors_in_use;
      got.overflow = out_ch.overflow;
      if (expected_colours.size() == 0) begin
        flag_mismatch($sformatf("result beat for vertex %0d with none expected", got.vertex));
      end else begin
        want = expected_colours.pop_front();
        if (got.vertex !== want.vertex)
          flag_mismatch($sformatf("colored_vertex %0d, want %0d", got.vertex, want.vertex));
        if (got.colour !== want.colour)
          flag_mismatch($sformatf("vertex %0d assigned_color %0d, want %0d",
                                  want.vertex, got.colour, want.colour));
        if (got.in_use !== want.in_use)
          flag_mismatch($sformatf("vertex %0d colors_in_use %0d, want %0d",
                                  want.vertex, got.in_use, want.in_use));
        if (got.overflow !== want.overflow)
          flag_mismatch($sformatf("vertex %0d overflow %0b, want %0b",
                                  want.vertex, got.overflow, want.overflow));
      end
    end
  end

  initial begin : stimulus
    int waited;
    rst                   <= 1'b1;
    in_ch.valid           <= 1'b0;
    in_ch.opcode          <= OP_ADJ;
    in_ch.vertex          <= '0;
    in_ch.neighbour       <= '0;
    in_ch.neighbour_valid <= 1'b0;
    in_ch.last_entry      <= 1'b0;
    wipe_colours();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_colour_exhaustion();
    test_random_graphs(150);
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_colours.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_colours.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", expected_colours.size()));
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #10000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ggc_pkg.sv
sv/ggc_if.sv
sv/ggc_color_ram.sv
sv/ggc_color_select.sv
sv/greedy_graph_coloring_core.sv
verif/tb_top.sv
